// ===== hdl/pgcd_pkg.sv =====
package pgcd_pkg;

  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int LimitW  = 8;
  localparam int RepW    = 4;
  localparam int SizeW   = 4;
  localparam int CodeW   = 4;
  localparam int BitCntW = 2;

  localparam logic [LimitW-1:0] LeaderLowRst  = 8'd16;
  localparam logic [LimitW-1:0] LeaderHighRst = 8'd24;
  localparam logic [LimitW-1:0] OneLimitRst   = 8'd5;
  localparam logic [LimitW-1:0] ZeroLimitRst  = 8'd7;
  localparam logic [RepW-1:0]   ConfirmRst    = 4'd5;
  localparam logic [SizeW-1:0]  SpotSizeRst   = 4'd5;

  // The last bit of a code arrives when this many bits are already held.
  localparam logic [BitCntW-1:0] LastBitCnt = 2'd3;

  typedef enum logic [2:0] {
    REG_LEADER_LOW  = 3'd0,
    REG_LEADER_HIGH = 3'd1,
    REG_ONE_LIMIT   = 3'd2,
    REG_ZERO_LIMIT  = 3'd3,
    REG_CONFIRM     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [LimitW-1:0] leader_low;
    logic [LimitW-1:0] leader_high;
    logic [LimitW-1:0] one_limit;
    logic [LimitW-1:0] zero_limit;
    logic [RepW-1:0]   confirm_repeats;
  } cfg_t;

  typedef struct packed {
    logic [SizeW-1:0] spot_size;
    logic             size_updated;
    logic             code_done;
    logic             frame_error;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic [SizeW-1:0] value;
  } lookup_t;

  // Maps a received four-bit code to a spot size from 1 to 10.
  function automatic lookup_t code_lookup(input logic [CodeW-1:0] code);
    lookup_t res;
    res.hit = 1'b1;
    unique case (code)
      4'h4:    res.value = 4'd1;
      4'hE:    res.value = 4'd2;
      4'hC:    res.value = 4'd3;
      4'hD:    res.value = 4'd4;
      4'h9:    res.value = 4'd5;
      4'hB:    res.value = 4'd6;
      4'hA:    res.value = 4'd7;
      4'h8:    res.value = 4'd8;
      4'h0:    res.value = 4'd9;
      4'h1:    res.value = 4'd10;
      default: begin
        res.hit   = 1'b0;
        res.value = '0;
      end
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/pgcd_cfg_regs.sv =====
module pgcd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pgcd_pkg::AddrW-1:0]  paddr,
  input  logic [pgcd_pkg::DataW-1:0]  pwdata,
  output logic [pgcd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output pgcd_pkg::cfg_t              cfg_o
);
  import pgcd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LEADER_LOW:  cfg_d.leader_low      = pwdata[LimitW-1:0];
        REG_LEADER_HIGH: cfg_d.leader_high     = pwdata[LimitW-1:0];
        REG_ONE_LIMIT:   cfg_d.one_limit       = pwdata[LimitW-1:0];
        REG_ZERO_LIMIT:  cfg_d.zero_limit      = pwdata[LimitW-1:0];
        REG_CONFIRM:     cfg_d.confirm_repeats = pwdata[RepW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEADER_LOW:  prdata = DataW'(cfg_q.leader_low);
      REG_LEADER_HIGH: prdata = DataW'(cfg_q.leader_high);
      REG_ONE_LIMIT:   prdata = DataW'(cfg_q.one_limit);
      REG_ZERO_LIMIT:  prdata = DataW'(cfg_q.zero_limit);
      REG_CONFIRM:     prdata = DataW'(cfg_q.confirm_repeats);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low      <= LeaderLowRst;
      cfg_q.leader_high     <= LeaderHighRst;
      cfg_q.one_limit       <= OneLimitRst;
      cfg_q.zero_limit      <= ZeroLimitRst;
      cfg_q.confirm_repeats <= ConfirmRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/pgcd_core.sv =====
module pgcd_core #(
  parameter int GAP_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [GAP_WIDTH-1:0]  gap_i,
  input  pgcd_pkg::cfg_t        cfg_i,
  output pgcd_pkg::result_t     res_o
);
  import pgcd_pkg::*;

  localparam int CmpW = (GAP_WIDTH > LimitW) ? GAP_WIDTH : LimitW;

  logic               in_frame_q, in_frame_d;
  logic [BitCntW-1:0] bits_q, bits_d;
  logic [CodeW-1:0]   shift_q, shift_d;
  logic [SizeW-1:0]   decoded_q, decoded_d;
  logic [SizeW-1:0]   prev_q, prev_d;
  logic [RepW-1:0]    repeat_q, repeat_d;
  logic [SizeW-1:0]   accepted_q, accepted_d;

  logic [CmpW-1:0]    gap;
  logic [RepW:0]      next_cnt;
  logic               is_one, is_zero;
  logic               updated, done, err;
  lookup_t            lk;

  assign gap      = CmpW'(gap_i);
  assign is_one   = gap < CmpW'(cfg_i.one_limit);
  assign is_zero  = gap < CmpW'(cfg_i.zero_limit);
  assign next_cnt = {1'b0, repeat_q} + 1'b1;
  assign lk       = code_lookup({shift_q[CodeW-2:0], is_one});

  always_comb begin
    in_frame_d = in_frame_q;
    bits_d     = bits_q;
    shift_d    = shift_q;
    decoded_d  = decoded_q;
    prev_d     = prev_q;
    repeat_d   = repeat_q;
    accepted_d = accepted_q;
    updated    = 1'b0;
    done       = 1'b0;
    err        = 1'b0;
    if (!in_frame_q) begin
      if (gap > CmpW'(cfg_i.leader_low) && gap < CmpW'(cfg_i.leader_high)) begin
        in_frame_d = 1'b1;
        shift_d    = '0;
        bits_d     = '0;
      end
    end else if (is_one || is_zero) begin
      shift_d = {shift_q[CodeW-2:0], is_one};
      if (bits_q == LastBitCnt) begin
        done = 1'b1;
        // An unmapped code leaves the last decoded value in place.
        if (lk.hit) begin
          decoded_d = lk.value;
        end
        if (prev_q == decoded_d) begin
          if (next_cnt > {1'b0, cfg_i.confirm_repeats}) begin
            if (decoded_d != '0) begin
              accepted_d = decoded_d;
              updated    = 1'b1;
            end
            repeat_d = '0;
          end else begin
            repeat_d = next_cnt[RepW-1:0];
          end
        end else begin
          repeat_d = '0;
        end
        prev_d     = decoded_d;
        in_frame_d = 1'b0;
        shift_d    = '0;
        bits_d     = '0;
      end else begin
        bits_d = bits_q + 1'b1;
      end
    end else begin
      // A bit gap that is too long drops the whole frame.
      err        = 1'b1;
      in_frame_d = 1'b0;
      shift_d    = '0;
      bits_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      bits_q     <= '0;
      shift_q    <= '0;
      decoded_q  <= '0;
      prev_q     <= '0;
      repeat_q   <= '0;
      accepted_q <= SpotSizeRst;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      bits_q     <= bits_d;
      shift_q    <= shift_d;
      decoded_q  <= decoded_d;
      prev_q     <= prev_d;
      repeat_q   <= repeat_d;
      accepted_q <= accepted_d;
    end
  end

  assign res_o.spot_size    = accepted_d;
  assign res_o.size_updated = updated;
  assign res_o.code_done    = done;
  assign res_o.frame_error  = err;

endmodule

// ===== hdl/pulse_gap_code_decoder.sv =====
// Path: a result passes through the input register and then the result register
// before it appears on the outputs.
// Throughput: one edge per clock; the input register, the decode logic and the
// result register advance together whenever the result register is free or taken.
// Reset (rst_ni low, asynchronous): all registers but gap_q and res_q return to
// their reset values, the decoder waits for a leader, and the accepted spot size is 5.
module pulse_gap_code_decoder #(
  parameter int GAP_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pgcd_pkg::AddrW-1:0]  paddr,
  input  logic [pgcd_pkg::DataW-1:0]  pwdata,
  output logic [pgcd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [GAP_WIDTH-1:0]        gap_ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pgcd_pkg::SizeW-1:0]  spot_size_o,
  output logic                        size_updated_o,
  output logic                        code_done_o,
  output logic                        frame_error_o
);
  import pgcd_pkg::*;

  cfg_t                 cfg;
  result_t              res, res_q;
  logic                 in_valid_q, out_valid_q;
  logic [GAP_WIDTH-1:0] gap_q;
  logic                 advance, step;

  pgcd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  pgcd_core #(
    .GAP_WIDTH (GAP_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .gap_i  (gap_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gap_q <= gap_ticks_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign spot_size_o    = res_q.spot_size;
  assign size_updated_o = res_q.size_updated;
  assign code_done_o    = res_q.code_done;
  assign frame_error_o  = res_q.frame_error;

endmodule

// ===== hdl/pgcd_checker.sv =====
module pgcd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [pgcd_pkg::SizeW-1:0]  spot_size_o,
  input logic                        size_updated_o,
  input logic                        code_done_o,
  input logic                        frame_error_o
);

  // A dropped frame never completes a code on the same edge.
  a_done_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(code_done_o && frame_error_o))
    else $error("code_done and frame_error reported together");

  // A size is only accepted at the end of a complete code.
  a_update_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_updated_o |-> code_done_o)
    else $error("size_updated without code_done");

  // The accepted size always lies between 1 and 10.
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (spot_size_o != 4'd0) && (spot_size_o <= 4'd10))
    else $error("spot_size out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(spot_size_o)
      && $stable(size_updated_o) && $stable(code_done_o) && $stable(frame_error_o))
    else $error("stalled result changed");

endmodule

bind pulse_gap_code_decoder pgcd_checker u_pgcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .spot_size_o    (spot_size_o),
  .size_updated_o (size_updated_o),
  .code_done_o    (code_done_o),
  .frame_error_o  (frame_error_o)
);
